// ----- hw/rtl/bb3_pkg.sv -----
// bb3_pkg: shared types, widths, register indexes and the reciprocal table of the 3x3 box blur
// no dependencies; used by the top level, bb3_line and bb3_mean by scoped names
`default_nettype none

package bb3_pkg;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int SUM_W   = 12;
	localparam int NUM_W   = SUM_W + 1;
	localparam int CNT_W   = 4;
	localparam int RECIP_W = 17;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 17;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [2:0][2:0][PIX_W-1:0] win_t;

	typedef struct packed {
		logic due;
		logic last;
		logic up;
		logic down;
		logic left;
		logic right;
	} tag_t;

	typedef struct packed {
		logic valid;
		tag_t tag;
	} s2_t;

	// ceil(2^17 / (2*count)); exact for every sum that count neighbours can give
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
		logic [RECIP_W-1:0] m;
		unique case (count)
			4'd1:    m = 17'd65536;
			4'd2:    m = 17'd32768;
			4'd3:    m = 17'd21846;
			4'd4:    m = 17'd16384;
			4'd6:    m = 17'd10923;
			4'd9:    m = 17'd7282;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/box_blur_3x3_edge_aware.sv -----
// box_blur_3x3_edge_aware: top level, configuration registers and stall control
// depends on bb3_pkg, bb3_line, bb3_mean (and bb3_ram through bb3_line)
//
// Streaming 3x3 box blur of an RGB raster. Pixel requests (mode 0) arrive in raster
// order; each result is the rounded-half-up mean of the in-frame 3x3 neighbourhood
// (4, 6 or 9 pixels, fewer for one-row or one-column frames). The result for a pixel
// leaves frame_width + 1 requests after it, so after the last pixel the host sends
// drain requests (mode 1) to flush; drains before the frame's last pixel, and drains
// with nothing left to flush, give no result. frame_end marks the final result,
// after which a new frame begins. A register write restarts the frame. The block
// takes one request per clock while results are taken; beyond the frame_width + 1
// request lag a result passes the first-stage, window, sum and result registers. The
// rate is set by the line memory, one MAX_WIDTH x 48-bit RAM holding the two rows
// above, read on take and written back from the first stage with forwarding. A result
// not taken holds the whole pipeline. The memory needs no clearing pass after reset.
`default_nettype none

module box_blur_3x3_edge_aware #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic        mode,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_end
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [10:0]         frame_width_q;
	logic [15:0]         frame_height_q;
	bb3_pkg::reg_idx_t   reg_idx;
	logic                cfg_wr;
	logic                adv;
	logic                take;
	logic [CW-1:0]       w_m1;
	logic [15:0]         h_m1;
	bb3_pkg::win_t       win;
	bb3_pkg::s2_t        ctl_s2;

	assign reg_idx     = bb3_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr      = psel && penable && pwrite;
	assign pready      = 1'b1;
	assign adv         = !result_valid || result_ready;
	assign pixel_ready = adv;
	assign take        = pixel_valid && adv;

	always_comb begin
		unique case (reg_idx)
			bb3_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, frame_width_q};
			bb3_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, frame_height_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 11'd1024;
			frame_height_q <= 16'd768;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				bb3_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[10:0];
				bb3_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[15:0];
				default:                   frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// clamped width and height, less one
	always_comb begin
		priority if (frame_width_q == '0) begin
			w_m1 = '0;
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_m1 = CW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = CW'(frame_width_q - 11'd1);
		end
		h_m1 = (frame_height_q == '0) ? '0 : frame_height_q - 16'd1;
	end

	bb3_line #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.take    (take),
		.restart (cfg_wr),
		.w_m1    (w_m1),
		.h_m1    (h_m1),
		.mode    (mode),
		.pix_in  ({blue_in, green_in, red_in}),
		.win     (win),
		.ctl     (ctl_s2)
	);

	bb3_mean u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.win    (win),
		.ctl    (ctl_s2),
		.valid  (result_valid),
		.red    (red_out),
		.green  (green_out),
		.blue   (blue_out),
		.last   (frame_end)
	);

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && ctl_s2.valid) |=> ctl_s2.valid)
		else $error("stalled window stage lost its request");

	a_last_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s2.valid && ctl_s2.tag.last) |-> (!ctl_s2.tag.down && !ctl_s2.tag.right))
		else $error("frame end flagged away from the bottom right corner");

	a_load_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(adv))
		else $error("result register loaded without advance");

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_ram.sv -----
// bb3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bb3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_line.sv -----
// bb3_line: position counters, line memory read-modify-write and 3x3 window
// depends on bb3_pkg and bb3_ram
`default_nettype none

module bb3_line #(
	parameter int MAX_WIDTH = 1024,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           take,
	input  logic           restart,
	input  logic [CW-1:0]  w_m1,
	input  logic [15:0]    h_m1,
	input  logic           mode,
	input  bb3_pkg::pix_t  pix_in,
	output bb3_pkg::win_t  win,
	output bb3_pkg::s2_t   ctl
);

	localparam int PW = bb3_pkg::PIX_W;

	logic [CW-1:0]  in_col_q;
	logic [16:0]    in_row_q;
	logic [CW-1:0]  out_col_q;
	logic [15:0]    out_row_q;

	logic           flushing;
	logic           eff;
	logic           col_last;
	logic           due;
	logic           last;
	bb3_pkg::tag_t  tag_new;

	logic           valid_s1;
	logic [CW-1:0]  col_s1;
	bb3_pkg::pix_t  pix_s1;
	bb3_pkg::tag_t  tag_s1;

	logic [2*PW-1:0] rd_data;
	logic [2*PW-1:0] row_pair;
	logic [2*PW-1:0] wr_data;
	logic            fwd_valid_q;
	logic [CW-1:0]   fwd_col_q;
	logic [2*PW-1:0] fwd_data_q;

	bb3_pkg::win_t  win_q;
	bb3_pkg::s2_t   ctl_s2;

	always_comb begin
		flushing = in_row_q > {1'b0, h_m1};
		eff      = take && (!mode || flushing);
		col_last = in_col_q == w_m1;
		due      = (in_row_q >= 17'd2) || (in_row_q == 17'd1 && in_col_q != '0);
		last     = (out_row_q == h_m1) && (out_col_q == w_m1);
		tag_new.due   = due;
		tag_new.last  = last;
		tag_new.up    = out_row_q != '0;
		tag_new.down  = out_row_q != h_m1;
		tag_new.left  = out_col_q != '0;
		tag_new.right = out_col_q != w_m1;
		// older row in the upper half, newer row in the lower half
		row_pair = (fwd_valid_q && fwd_col_q == col_s1) ? fwd_data_q : rd_data;
		wr_data  = {row_pair[PW-1:0], pix_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			priority if (restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (eff && due && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (eff) begin
				if (col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 17'd1;
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (due) begin
					if (out_col_q == w_m1) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 16'd1;
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end else begin
				in_col_q <= in_col_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= eff;
		end
	end

	always_ff @(posedge clk) begin
		if (eff) begin
			col_s1 <= in_col_q;
			pix_s1 <= flushing ? '0 : pix_in;
			tag_s1 <= tag_new;
		end
	end

	bb3_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (adv && valid_s1),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (eff),
		.raddr (in_col_q),
		.rdata (rd_data)
	);

	// window shift and forwarding of the last write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			ctl_s2      <= '0;
			fwd_valid_q <= 1'b0;
			fwd_col_q   <= '0;
			fwd_data_q  <= '0;
		end else if (adv) begin
			ctl_s2.valid <= valid_s1 && tag_s1.due;
			ctl_s2.tag   <= tag_s1;
			if (valid_s1) begin
				for (int dy = 0; dy < 3; dy++) begin
					win_q[dy][0] <= win_q[dy][1];
					win_q[dy][1] <= win_q[dy][2];
				end
				win_q[0][2] <= row_pair[2*PW-1:PW];
				win_q[1][2] <= row_pair[PW-1:0];
				win_q[2][2] <= pix_s1;
				fwd_valid_q <= 1'b1;
				fwd_col_q   <= col_s1;
				fwd_data_q  <= wr_data;
			end
		end
	end

	assign win = win_q;
	assign ctl = ctl_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_mean.sv -----
// bb3_mean: masked 3x3 sums, rounded division by the neighbour count, result register
// depends on bb3_pkg
`default_nettype none

module bb3_mean (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  bb3_pkg::win_t win,
	input  bb3_pkg::s2_t  ctl,
	output logic          valid,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic          last
);

	localparam int SW = bb3_pkg::SUM_W;
	localparam int CHW = bb3_pkg::CH_W;

	logic [2:0]                   row_en;
	logic [2:0]                   col_en;
	logic [1:0]                   nr;
	logic [1:0]                   nc;
	logic [bb3_pkg::CNT_W-1:0]    count;
	logic [2:0][SW-1:0]           sums;

	logic                         valid_s3;
	logic [2:0][SW-1:0]           sum_s3;
	logic [bb3_pkg::CNT_W-1:0]    count_s3;
	logic                         last_s3;

	logic [bb3_pkg::RECIP_W-1:0]  recip;
	logic [2:0][bb3_pkg::NUM_W-1:0]  num;
	logic [2:0][bb3_pkg::PROD_W-1:0] prod;
	logic [2:0][CHW-1:0]          mean;

	logic                         valid_q;
	logic [2:0][CHW-1:0]          mean_q;
	logic                         last_q;

	always_comb begin
		row_en = {ctl.tag.down, 1'b1, ctl.tag.up};
		col_en = {ctl.tag.right, 1'b1, ctl.tag.left};
		nr     = 2'd1 + 2'(ctl.tag.up) + 2'(ctl.tag.down);
		nc     = 2'd1 + 2'(ctl.tag.left) + 2'(ctl.tag.right);
		count  = bb3_pkg::CNT_W'(nr) * bb3_pkg::CNT_W'(nc);
		for (int ch = 0; ch < 3; ch++) begin
			sums[ch] = '0;
			for (int dy = 0; dy < 3; dy++) begin
				for (int dx = 0; dx < 3; dx++) begin
					if (row_en[dy] && col_en[dx]) begin
						sums[ch] = sums[ch] + SW'(win[dy][dx][CHW*ch +: CHW]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3   <= sums;
			count_s3 <= count;
			last_s3  <= ctl.tag.last;
		end
	end

	// (2*sum + count) / (2*count) by reciprocal multiplication
	always_comb begin
		recip = bb3_pkg::recip(count_s3);
		for (int ch = 0; ch < 3; ch++) begin
			num[ch]  = {sum_s3[ch], 1'b0} + bb3_pkg::NUM_W'(count_s3);
			prod[ch] = bb3_pkg::PROD_W'(num[ch]) * bb3_pkg::PROD_W'(recip);
			mean[ch] = prod[ch][bb3_pkg::RECIP_SHIFT +: CHW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_q <= mean;
			last_q <= last_s3;
		end
	end

	assign valid = valid_q;
	assign red   = mean_q[0];
	assign green = mean_q[1];
	assign blue  = mean_q[2];
	assign last  = last_q;

endmodule

`default_nettype wire
